>>> rtl/core/csrp_pkg.sv
// Shared types and constants for the compressed-row row/column permuter.
package csrp_pkg;

  localparam int FIELD_W = 13;
  localparam int OUT_W   = 8;

  typedef enum logic [1:0] {
    REQ_ROW_START = 2'd0,
    REQ_COL_INDEX = 2'd1,
    REQ_PERM      = 2'd2,
    REQ_EMIT      = 2'd3
  } req_t;

  localparam logic [1:0] MODE_ROWS = 2'd0;
  localparam logic [1:0] MODE_COLS = 2'd1;
  localparam logic [1:0] MODE_BOTH = 2'd2;

  typedef struct packed {
    req_t               kind;
    logic [FIELD_W-1:0] pos;
    logic [FIELD_W-1:0] val;
  } item_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_t;

endpackage

>>> rtl/core/csrp_front.sv
// Front end: accepts transactions, drops out-of-range ones, pushes the rest.
module csrp_front #(
  parameter int DIM_MAX = 256,
  parameter int NNZ_MAX = 4096
) (
  input  logic                 start,
  input  logic [1:0]           req_type,
  input  logic [12:0]          position,
  input  logic [12:0]          value,
  input  logic                 q_full,
  output logic                 busy,
  output logic                 push,
  output csrp_pkg::item_t      item
);
  import csrp_pkg::*;

  logic in_range;
  logic [31:0] pos32, val32;

  assign pos32 = 32'(position);
  assign val32 = 32'(value);

  always_comb begin
    unique case (req_t'(req_type))
      REQ_ROW_START: in_range = pos32 < 32'(DIM_MAX + 1);
      REQ_COL_INDEX: in_range = pos32 < 32'(NNZ_MAX);
      REQ_PERM:      in_range = (pos32 < 32'(DIM_MAX)) && (val32 < 32'(DIM_MAX));
      REQ_EMIT:      in_range = pos32 < 32'(DIM_MAX);
      default:       in_range = 1'b0;
    endcase
  end

  assign busy      = q_full;
  assign push      = start && !q_full && in_range;
  assign item.kind = req_t'(req_type);
  assign item.pos  = position;
  assign item.val  = value;
endmodule

>>> rtl/core/csrp_queue.sv
// Two-entry queue between the front end and the back end.
module csrp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  csrp_pkg::item_t din,
  input  logic            pop,
  output csrp_pkg::item_t dout,
  output logic            full,
  output logic            empty
);
  import csrp_pkg::*;

  item_t      slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> rtl/core/csrp_back.sv
// Back end: table memories, row walk, insertion sort and result sequencing.
module csrp_back #(
  parameter int DIM_MAX = 256,
  parameter int NNZ_MAX = 4096,
  parameter int ROW_MAX = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      permute_mode,
  input  csrp_pkg::item_t item,
  input  logic            q_empty,
  output logic            pop,
  output logic            result_valid,
  output logic [7:0]      out_row,
  output logic [7:0]      out_col,
  output logic            has_entry,
  output logic            last_of_row,
  output logic            row_overflow
);
  import csrp_pkg::*;

  localparam int DW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int RW = $clog2(DIM_MAX + 1);
  localparam int NW = (NNZ_MAX > 1) ? $clog2(NNZ_MAX) : 1;
  localparam int CW = $clog2(ROW_MAX + 1);
  localparam int KW = FIELD_W;

  typedef enum logic [2:0] {S_IDLE, S_ROW, S_BND, S_FETCH, S_OUT} state_t;

  state_t state;

  logic [KW-1:0] row_start_mem [DIM_MAX+1];
  logic [KW-1:0] column_mem    [NNZ_MAX];
  logic [DW-1:0] perm_mem      [DIM_MAX];
  logic [DW-1:0] inverse_mem   [DIM_MAX];

  logic [DW-1:0] inv_q, perm_q;
  logic [KW-1:0] rs0_q, rs1_q, col_q;

  logic [KW-1:0] cur_pos;
  logic [NW-1:0] colptr;
  logic [CW-1:0] cnt, iss, fill, rem;
  logic          ovf;
  logic          s1, s2, m2;
  logic [KW-1:0] c2;

  logic [KW-1:0] sbuf [ROW_MAX];
  logic [KW-1:0] ins  [ROW_MAX];
  logic [KW-1:0] shf  [ROW_MAX];

  logic          rows_perm, cols_perm;
  logic [DW-1:0] old_row;
  logic [RW-1:0] old_row_ext;
  logic [KW-1:0] end_off, diff, key;
  logic          issue, use_perm;

  assign rows_perm   = permute_mode != MODE_COLS;
  assign cols_perm   = permute_mode != MODE_ROWS;
  assign pop         = state == S_IDLE && !q_empty;
  assign old_row     = rows_perm ? inv_q : DW'(cur_pos);
  assign old_row_ext = RW'(old_row);
  assign end_off     = (32'(rs1_q) > 32'(NNZ_MAX)) ? KW'(NNZ_MAX) : rs1_q;
  assign diff        = end_off - rs0_q;
  assign issue       = state == S_FETCH && iss < cnt;
  assign use_perm    = cols_perm && (32'(col_q) < 32'(DIM_MAX));
  assign key         = m2 ? KW'(perm_q) : c2;

  always_ff @(posedge clk) begin
    if (pop && item.kind == REQ_ROW_START) row_start_mem[RW'(item.pos)] <= item.val;
    if (pop && item.kind == REQ_COL_INDEX) column_mem[NW'(item.pos)] <= item.val;
    if (pop && item.kind == REQ_PERM) begin
      perm_mem[DW'(item.pos)]    <= DW'(item.val);
      inverse_mem[DW'(item.val)] <= DW'(item.pos);
    end
    inv_q  <= inverse_mem[DW'(item.pos)];
    rs0_q  <= row_start_mem[old_row_ext];
    rs1_q  <= row_start_mem[old_row_ext + RW'(1)];
    col_q  <= column_mem[colptr];
    perm_q <= perm_mem[DW'(col_q)];
  end

  for (genvar k = 0; k < ROW_MAX; k++) begin : g_buf
    logic valid_k, le_k, le_prev;
    assign valid_k = CW'(k) < fill;
    assign le_k    = sbuf[k] <= key;
    if (k == 0) begin : g_first
      assign le_prev = 1'b1;
      assign ins[k] = !cols_perm ? ((fill == CW'(k)) ? key : sbuf[k]) :
                      (valid_k && le_k) ? sbuf[k] :
                      le_prev ? key : sbuf[k];
    end else begin : g_rest
      assign le_prev = sbuf[k-1] <= key;
      assign ins[k] = !cols_perm ? ((fill == CW'(k)) ? key : sbuf[k]) :
                      (valid_k && le_k) ? sbuf[k] :
                      le_prev ? key : sbuf[k-1];
    end
    if (k == ROW_MAX - 1) begin : g_tail
      assign shf[k] = sbuf[k];
    end else begin : g_mid
      assign shf[k] = sbuf[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FETCH && s2) sbuf <= ins;
    if (state == S_OUT) sbuf <= shf;
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      s1           <= 1'b0;
      s2           <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      s1 <= issue;
      s2 <= s1;
      m2 <= use_perm;
      c2 <= col_q;
      unique case (state)
        S_IDLE: begin
          if (pop && item.kind == REQ_EMIT) begin
            cur_pos <= item.pos;
            state   <= S_ROW;
          end
        end
        S_ROW: state <= S_BND;
        S_BND: begin
          if (rs0_q >= end_off) begin
            result_valid <= 1'b1;
            out_row      <= OUT_W'(cur_pos);
            out_col      <= '0;
            has_entry    <= 1'b0;
            last_of_row  <= 1'b1;
            row_overflow <= 1'b0;
            state        <= S_IDLE;
          end else begin
            ovf    <= 32'(diff) > 32'(ROW_MAX);
            cnt    <= (32'(diff) > 32'(ROW_MAX)) ? CW'(ROW_MAX) : CW'(diff);
            colptr <= NW'(rs0_q);
            iss    <= '0;
            fill   <= '0;
            state  <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (issue) begin
            colptr <= colptr + NW'(1);
            iss    <= iss + CW'(1);
          end
          if (s2) begin
            fill <= fill + CW'(1);
            if (fill + CW'(1) == cnt) begin
              rem   <= cnt;
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          result_valid <= 1'b1;
          out_row      <= OUT_W'(cur_pos);
          out_col      <= OUT_W'(sbuf[0]);
          has_entry    <= 1'b1;
          last_of_row  <= rem == CW'(1);
          row_overflow <= ovf;
          rem          <= rem - CW'(1);
          if (rem == CW'(1)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/csr_row_column_permute_top.sv
// Top level of the compressed-row sparsity row/column permuter.
// Load transactions: queued, then written to their table; one per cycle sustained
// while no emit is in progress. Emit: inverse and row-start lookups, a column and
// permutation walk, insertion-sorted if columns permute, then one result per cycle.
// The two-entry queue sets busy; results cannot be stalled by the receiver.
// Reset (synchronous) empties the queue and sets permute_mode to 2; tables are unset.
module csr_row_column_permute_top #(
  parameter int DIM_MAX = 256,
  parameter int NNZ_MAX = 4096,
  parameter int ROW_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [12:0] position,
  input  logic [12:0] value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  output logic        result_valid,
  output logic [7:0]  out_row,
  output logic [7:0]  out_col,
  output logic        has_entry,
  output logic        last_of_row,
  output logic        row_overflow
);
  import csrp_pkg::*;

  logic [1:0] permute_mode;
  item_t      f_item, q_item;
  q_wr_t      qw;
  q_rd_t      qr;

  always_ff @(posedge clk) begin
    if (rst) permute_mode <= MODE_BOTH;
    else if (cfg_we) permute_mode <= cfg_data;
  end

  csrp_front #(.DIM_MAX(DIM_MAX), .NNZ_MAX(NNZ_MAX)) u_front (
    .start(start), .req_type(req_type), .position(position), .value(value),
    .q_full(qw.full), .busy(busy), .push(qw.push), .item(f_item)
  );

  csrp_queue u_queue (
    .clk(clk), .rst(rst), .push(qw.push), .din(f_item), .pop(qr.pop),
    .dout(q_item), .full(qw.full), .empty(qr.empty)
  );

  csrp_back #(.DIM_MAX(DIM_MAX), .NNZ_MAX(NNZ_MAX), .ROW_MAX(ROW_MAX)) u_back (
    .clk(clk), .rst(rst), .permute_mode(permute_mode), .item(q_item),
    .q_empty(qr.empty), .pop(qr.pop), .result_valid(result_valid),
    .out_row(out_row), .out_col(out_col), .has_entry(has_entry),
    .last_of_row(last_of_row), .row_overflow(row_overflow)
  );

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !has_entry |-> last_of_row && !row_overflow)
    else $error("empty row result malformed");

  a_row_contig: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_row |=> result_valid && has_entry && $stable(out_row))
    else $error("row results not contiguous");

  a_ovf_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_row |=> $stable(row_overflow))
    else $error("overflow flag changed within row");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the compressed-row row/column permuter top level.
`timescale 1ns / 1ps

module tb_top;
  import csrp_pkg::*;

  localparam int DIM = 256;
  localparam int NNZ = 4096;
  localparam int RMAX = 32;
  localparam int NROW = 16;
  localparam int NCOL = 56;
  localparam int SETTLE = 2 * RMAX + 20;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic       has;
    logic       last;
    logic       ovf;
  } entry_t;

  typedef struct packed {
    req_t        kind;
    logic [12:0] pos;
    logic [12:0] val;
    logic        lit;
    entry_t      want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [12:0] position;
  logic [12:0] value;
  logic        cfg_we;
  logic [1:0]  cfg_data;
  logic        result_valid;
  logic [7:0]  out_row;
  logic [7:0]  out_col;
  logic        has_entry;
  logic        last_of_row;
  logic        row_overflow;

  csr_row_column_permute_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .position(position), .value(value),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .result_valid(result_valid), .out_row(out_row), .out_col(out_col),
    .has_entry(has_entry), .last_of_row(last_of_row), .row_overflow(row_overflow)
  );

  // shadow state
  int unsigned row_start_sh[DIM+1];
  int unsigned col_sh[NNZ];
  int unsigned perm_sh[DIM];
  int unsigned inv_sh[DIM];
  logic [1:0]  mode_sh;

  entry_t pending_q[$];
  int     mismatches;
  bit     failed;
  int     burst_left;
  bit     pace_on;

  dir_row_t dir_tab[24];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic permute_row(input logic [1:0] kind, input int unsigned pos,
                             input int unsigned val);
    int unsigned old_row, rs, re, cnt, key, i, j;
    int unsigned buf_c[RMAX];
    bit rows_p, cols_p, ovf;
    entry_t e;
    rows_p = (mode_sh != MODE_COLS);
    cols_p = (mode_sh != MODE_ROWS);
    ovf = 1'b0;
    case (kind)
      REQ_ROW_START: if (pos < DIM + 1) row_start_sh[pos] = val;
      REQ_COL_INDEX: if (pos < NNZ) col_sh[pos] = val;
      REQ_PERM: begin
        if (pos < DIM && val < DIM) begin
          perm_sh[pos] = val;
          inv_sh[val] = pos;
        end
      end
      default: begin
        if (pos < DIM) begin
          old_row = rows_p ? inv_sh[pos] : pos;
          if (old_row >= DIM) old_row = 0;
          rs = row_start_sh[old_row];
          re = row_start_sh[old_row + 1];
          if (re > NNZ) re = NNZ;
          if (rs >= re) begin
            e = '{row: pos[7:0], col: 8'd0, has: 1'b0, last: 1'b1, ovf: 1'b0};
            pending_q.insert(pending_q.size(), e);
          end else begin
            cnt = re - rs;
            if (cnt > RMAX) begin
              cnt = RMAX;
              ovf = 1'b1;
            end
            for (i = 0; i < cnt; i++) begin
              buf_c[i] = col_sh[rs + i];
              if (cols_p && buf_c[i] < DIM) buf_c[i] = perm_sh[buf_c[i]];
            end
            if (cols_p) begin
              for (i = 1; i < cnt; i++) begin
                key = buf_c[i];
                j = i;
                while (j > 0 && buf_c[j-1] > key) begin
                  buf_c[j] = buf_c[j-1];
                  j--;
                end
                buf_c[j] = key;
              end
            end
            for (i = 0; i < cnt; i++) begin
              e = '{row: pos[7:0], col: buf_c[i][7:0], has: 1'b1,
                    last: (i + 1 == cnt), ovf: ovf};
              pending_q.insert(pending_q.size(), e);
            end
          end
        end
      end
    endcase
  endtask

  // called just after a rising edge; returns just after the accepting edge
  task automatic send(input logic [1:0] kind, input int unsigned pos,
                      input int unsigned val, input bit lit, input entry_t want);
    start    <= 1'b1;
    req_type <= kind;
    position <= pos[12:0];
    value    <= val[12:0];
    do @(posedge clk); while (busy);
    if (lit) pending_q.insert(pending_q.size(), want);
    else permute_row(kind, pos, val);
    if (pace_on) begin
      if (burst_left > 0) burst_left--;
      else begin
        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
      end
    end
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    mode_sh = m;
  endtask

  task automatic random_item();
    int unsigned r, a, b, pa, pb;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      a = ($urandom_range(0, 19) == 0) ? $urandom_range(DIM, 8191) : $urandom_range(0, NROW - 1);
      send(REQ_EMIT, a, 0, 1'b0, '0);
    end else if (r < 72) begin
      a = ($urandom_range(0, 9) == 0) ? $urandom_range(NNZ, 8191) : $urandom_range(0, NCOL - 1);
      b = ($urandom_range(0, 15) == 0) ? $urandom_range(DIM, 8191) : $urandom_range(0, NROW - 1);
      send(REQ_COL_INDEX, a, b, 1'b0, '0);
    end else if (r < 82) begin
      a = ($urandom_range(0, 9) == 0) ? $urandom_range(DIM + 1, 8191) : $urandom_range(0, NROW);
      b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, NCOL)
                                      : row_start_sh[a % (DIM + 1)] + $urandom_range(0, 6);
      if (b > NCOL) b = NCOL;
      send(REQ_ROW_START, a, b, 1'b0, '0);
    end else if (r < 94) begin
      // swap two entries so the permutation stays valid
      a = $urandom_range(0, NROW - 1);
      b = $urandom_range(0, NROW - 1);
      pa = perm_sh[a];
      pb = perm_sh[b];
      send(REQ_PERM, a, pb, 1'b0, '0);
      send(REQ_PERM, b, pa, 1'b0, '0);
    end else begin
      a = $urandom_range(DIM, 8191);
      b = $urandom_range(0, 8191);
      send(REQ_PERM, a, b, 1'b0, '0);
      send(REQ_PERM, $urandom_range(0, DIM - 1), $urandom_range(DIM, 8191), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    entry_t got, want;
    if (!rst && result_valid) begin
      got = '{row: out_row, col: out_col, has: has_entry, last: last_of_row,
              ovf: row_overflow};
      if (pending_q.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  initial begin
    int unsigned acc, len, k;
    logic [1:0] modes[4];
    mismatches = 0;
    failed = 1'b0;
    burst_left = 0;
    pace_on = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    req_type = REQ_ROW_START;
    position = '0;
    value = '0;
    cfg_we = 1'b0;
    cfg_data = MODE_BOTH;
    mode_sh = MODE_BOTH;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every slot the stimulus can reach: rows below NROW, row starts up to NROW, columns below NCOL
    for (int p = 0; p < NROW; p++) send(REQ_PERM, p, p, 1'b0, '0);
    acc = 0;
    for (int r = 0; r <= NROW; r++) begin
      send(REQ_ROW_START, r, acc, 1'b0, '0);
      len = (r == 5) ? 36 : $urandom_range(0, 1);
      acc = (acc + len > NCOL) ? NCOL : acc + len;
    end
    for (int c = 0; c < NCOL; c++) begin
      k = ($urandom_range(0, 15) == 0) ? $urandom_range(DIM, 8191) : $urandom_range(0, NROW - 1);
      send(REQ_COL_INDEX, c, k, 1'b0, '0);
    end

    dir_tab = '{
      '{REQ_ROW_START, 13'd3,    13'd20,   1'b0, '0},
      '{REQ_ROW_START, 13'd4,    13'd20,   1'b0, '0},
      '{REQ_EMIT,      13'd3,    13'd0,    1'b1, '{8'd3, 8'd0, 1'b0, 1'b1, 1'b0}},
      '{REQ_ROW_START, 13'd7,    13'd0,    1'b0, '0},
      '{REQ_ROW_START, 13'd8,    13'd40,   1'b0, '0},
      '{REQ_EMIT,      13'd7,    13'd0,    1'b0, '0},
      '{REQ_ROW_START, 13'd9,    13'd5000, 1'b0, '0},
      '{REQ_ROW_START, 13'd10,   13'd8191, 1'b0, '0},
      '{REQ_EMIT,      13'd9,    13'd0,    1'b1, '{8'd9, 8'd0, 1'b0, 1'b1, 1'b0}},
      '{REQ_ROW_START, 13'd9,    13'd50,   1'b0, '0},
      '{REQ_ROW_START, 13'd10,   13'd50,   1'b0, '0},
      '{REQ_COL_INDEX, 13'd0,    13'd8191, 1'b0, '0},
      '{REQ_COL_INDEX, 13'd4096, 13'd0,    1'b0, '0},
      '{REQ_ROW_START, 13'd257,  13'd0,    1'b0, '0},
      '{REQ_ROW_START, 13'd8191, 13'd0,    1'b0, '0},
      '{REQ_COL_INDEX, 13'd8191, 13'd8191, 1'b0, '0},
      '{REQ_PERM,      13'd8191, 13'd0,    1'b0, '0},
      '{REQ_PERM,      13'd0,    13'd8191, 1'b0, '0},
      '{REQ_EMIT,      13'd8191, 13'd8191, 1'b0, '0},
      '{REQ_EMIT,      13'd256,  13'd0,    1'b0, '0},
      '{REQ_PERM,      13'd0,    13'd15,   1'b0, '0},
      '{REQ_PERM,      13'd15,   13'd0,    1'b0, '0},
      '{REQ_EMIT,      13'd0,    13'd0,    1'b0, '0},
      '{REQ_EMIT,      13'd15,   13'd0,    1'b0, '0}
    };
    foreach (dir_tab[i])
      send(dir_tab[i].kind, dir_tab[i].pos, dir_tab[i].val, dir_tab[i].lit, dir_tab[i].want);
    quiesce();

    modes = '{MODE_ROWS, MODE_COLS, 2'd3, MODE_BOTH};
    pace_on = 1'b1;
    foreach (modes[m]) begin
      set_mode(modes[m]);
      for (int n = 0; n < 25; n++) random_item();
      quiesce();
    end

    if (!failed && mismatches == 0 && pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
